// ===== hdl/track_time_to_cell_walker_core_assert.svh =====
// assertion macros shared by the walker modules
`ifndef TRACK_TIME_TO_CELL_WALKER_CORE_ASSERT_SVH
`define TRACK_TIME_TO_CELL_WALKER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TTCW_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("ttcw check failed");
`define TTCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ttcw check failed");
`else
`define TTCW_ASSERT(lbl, prop)
`define TTCW_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ===== hdl/ttcw_pkg.sv =====
package ttcw_pkg;

  localparam int unsigned MaxCells = 262144;
  localparam int unsigned PosW     = $clog2(MaxCells);
  localparam int unsigned LenW     = PosW + 1;
  localparam int unsigned GrpW     = PosW - 3;
  localparam int unsigned Groups   = MaxCells / 8;
  localparam int unsigned RateW    = 24;
  localparam int unsigned DivW     = 48;
  localparam int unsigned IterW    = 6;
  localparam int unsigned RateBits = 29;
  localparam int unsigned IncW     = RateBits;
  localparam int unsigned HalfGiga = 500000000;

  localparam logic [DivW-1:0] RateDividend = DivW'(HalfGiga) << (DivW - RateBits);

  localparam logic [1:0] CfgTrackCells = 2'd0;
  localparam logic [1:0] CfgVarRate    = 2'd1;
  localparam logic [1:0] CfgFixedRate  = 2'd2;

  typedef enum logic [1:0] {
    ModeLoad = 2'd0,
    ModeWalk = 2'd1,
    ModeFill = 2'd2,
    ModeMark = 2'd3
  } mode_e;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [DivW-1:0] divisor;
    logic [IterW-1:0] iters;
  } div_req_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [DivW-1:0] quot;
    logic [DivW-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic             rate_we;
    logic [GrpW-1:0]  rate_waddr;
    logic [RateW-1:0] rate_wdata;
    logic [GrpW-1:0]  rate_raddr;
    logic             mark_we;
    logic [GrpW-1:0]  mark_waddr;
    logic [GrpW-1:0]  mark_raddr;
  } store_req_t;

  typedef struct packed {
    logic             busy;
    logic [RateW-1:0] rate_rdata;
    logic             mark_rdata;
  } store_rsp_t;

endpackage

// ===== hdl/ttcw_div.sv =====
module ttcw_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ttcw_pkg::div_req_t req_i,
  output ttcw_pkg::div_rsp_t rsp_o
);
  `include "track_time_to_cell_walker_core_assert.svh"

  logic                        busy_q, done_q;
  logic [ttcw_pkg::IterW-1:0]  cnt_q;
  logic [ttcw_pkg::DivW-1:0]   r_q, q_q, d_q;
  logic [ttcw_pkg::DivW:0]     r2, diff;
  logic                        ge;

  assign r2   = {r_q, q_q[ttcw_pkg::DivW-1]};
  assign diff = r2 - {1'b0, d_q};
  assign ge   = r2 >= {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= req_i.iters;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == ttcw_pkg::IterW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      r_q <= '0;
      q_q <= req_i.dividend;
      d_q <= req_i.divisor;
    end else if (busy_q) begin
      r_q <= ge ? diff[ttcw_pkg::DivW-1:0] : r2[ttcw_pkg::DivW-1:0];
      q_q <= {q_q[ttcw_pkg::DivW-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = q_q;
  assign rsp_o.rem  = r_q;

  `TTCW_ASSERT_IMP(a_rem_below_divisor, busy_q, r_q < d_q)
  `TTCW_ASSERT_IMP(a_done_not_busy, done_q, !busy_q)
  `TTCW_ASSERT(a_done_after_busy, done_q |-> $past(busy_q))

endmodule

// ===== hdl/ttcw_store.sv =====
module ttcw_store (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ttcw_pkg::store_req_t  req_i,
  output ttcw_pkg::store_rsp_t  rsp_o
);

  logic [ttcw_pkg::RateW-1:0] rate_mem [ttcw_pkg::Groups];
  logic                       mark_mem [ttcw_pkg::Groups];
  logic [ttcw_pkg::RateW-1:0] rate_rdata_q;
  logic                       mark_rdata_q;
  logic [ttcw_pkg::GrpW-1:0]  clr_cnt_q;
  logic                       clr_busy_q;

  // clearing sweep of the mark store after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rate_we) begin
      rate_mem[req_i.rate_waddr] <= req_i.rate_wdata;
    end
    rate_rdata_q <= rate_mem[req_i.rate_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mark_mem[clr_cnt_q] <= 1'b0;
    end else if (req_i.mark_we) begin
      mark_mem[req_i.mark_waddr] <= 1'b1;
    end
    mark_rdata_q <= mark_mem[req_i.mark_raddr];
  end

  assign rsp_o.busy       = clr_busy_q;
  assign rsp_o.rate_rdata = rate_rdata_q;
  assign rsp_o.mark_rdata = mark_rdata_q;

endmodule

// ===== hdl/track_time_to_cell_walker_core.sv =====
// Track time-to-cell walker.
// Input channel: in_valid_i / in_stall_o with mode, position, rate, duration,
// offset, fill and backward fields. Output channel: out_valid_o / out_stall_i
// with end position, mark bit and stall flag, one result per request.
// Configuration: cfg_we_i writes register cfg_index_i (0 track cells,
// 1 variable rate, 2 fixed rate) with cfg_data_i. The user must write only
// while idle; the block itself does not enforce it. A walk steps one cell
// per cycle but for its waits: each time the walk enters a new 8-cell group
// in variable rate mode it waits for a rate memory read, and a nonzero rate
// differing from the last one adds a restoring division for the per-cell
// time. A fixed rate walk divides once at its start. A walk that completes
// a full revolution short of the target takes one remainder division to
// skip the whole revolutions. A fill walk runs its offset walk first.
// One request is worked at a time; the next is taken once the result sits in
// the output register, which holds it while out_stall_i is high.
// After reset all 32768 groups of the mark store are cleared with in_stall_o high.
module track_time_to_cell_walker_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [17:0] position_i,
  input  logic [23:0] rate_value_i,
  input  logic [23:0] duration_us_i,
  input  logic signed [24:0] offset_us_i,
  input  logic        fill_i,
  input  logic        backward_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [17:0] end_position_o,
  output logic        mark_bit_o,
  output logic        stalled_o
);
  `include "track_time_to_cell_walker_core_assert.svh"

  localparam int unsigned PosW = ttcw_pkg::PosW;
  localparam int unsigned LenW = ttcw_pkg::LenW;
  localparam int unsigned GrpW = ttcw_pkg::GrpW;
  localparam int unsigned DivW = ttcw_pkg::DivW;

  typedef enum logic [3:0] {
    S_IDLE, S_MARK, S_INIT, S_RATE, S_RWAIT, S_DIV, S_STEP, S_MODGO, S_MOD, S_OUT
  } state_e;

  ttcw_pkg::div_req_t   div_req;
  ttcw_pkg::div_rsp_t   div_rsp;
  ttcw_pkg::store_req_t st_req;
  ttcw_pkg::store_rsp_t st_rsp;

  ttcw_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));
  ttcw_store u_store (.clk_i, .rst_ni, .req_i(st_req), .rsp_o(st_rsp));

  // configuration
  logic [LenW-1:0]           track_cells_q;
  logic                      var_rate_q;
  logic [ttcw_pkg::RateW-1:0] fixed_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_cells_q <= LenW'(ttcw_pkg::MaxCells);
      var_rate_q    <= 1'b0;
      fixed_rate_q  <= ttcw_pkg::RateW'(250000);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ttcw_pkg::CfgTrackCells: track_cells_q <= cfg_data_i[LenW-1:0];
        ttcw_pkg::CfgVarRate:    var_rate_q    <= cfg_data_i[0];
        ttcw_pkg::CfgFixedRate:  fixed_rate_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [LenW-1:0] eff_len;
  assign eff_len = (track_cells_q == '0) ? LenW'(1) :
                   (track_cells_q > LenW'(ttcw_pkg::MaxCells)) ? LenW'(ttcw_pkg::MaxCells) :
                   track_cells_q;

  // control state
  state_e          state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            phase_q, phase_d;
  logic            rev_q, rev_d;
  logic            inc_ok_q, inc_ok_d;
  logic            stall_q, stall_d;

  // payload
  ttcw_pkg::mode_e mode_q, mode_d;
  logic [PosW-1:0] start_q, start_d;
  logic [PosW-1:0] pos_q, pos_d;
  logic [23:0]     dur_q, dur_d;
  logic [24:0]     mag_q, mag_d;
  logic            neg_q, neg_d;
  logic            fill_q, fill_d;
  logic            back_q, back_d;
  logic            wback_q, wback_d;
  logic            wfill_q, wfill_d;
  logic            grp_ok_q, grp_ok_d;
  logic [DivW-1:0] need_q, need_d;
  logic [DivW-1:0] t_q, t_d;
  logic [LenW-1:0] steps_q, steps_d;
  logic [ttcw_pkg::IncW-1:0]  inc_q, inc_d;
  logic [ttcw_pkg::RateW-1:0] last_rate_q, last_rate_d;
  logic [PosW-1:0] res_pos_q, res_pos_d;
  logic            res_mark_q, res_mark_d;
  logic [PosW-1:0] end_pos_q, end_pos_d;
  logic            mark_out_q, mark_out_d;
  logic            stall_out_q, stall_out_d;

  logic            in_acc, out_load, first;
  logic [24:0]     us_sel, off_raw;
  logic [PosW-1:0] start_sel, pos_next;
  logic [LenW-1:0] pos_inc, steps_inc;
  logic [DivW-1:0] t_sum, us_w;
  logic            hit;
  logic [ttcw_pkg::RateW-1:0] rate_cur;

  assign in_stall_o = !((state_q == S_IDLE) && !st_rsp.busy);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign first      = (mode_q == ttcw_pkg::ModeFill) && !phase_q;
  assign off_raw    = offset_us_i;
  assign us_sel     = first ? mag_q : {1'b0, dur_q};
  assign us_w       = DivW'(us_sel);
  assign start_sel  = first ? '0 : start_q;
  assign pos_inc    = {1'b0, pos_q} + 1'b1;
  assign pos_next   = wback_q ? ((pos_q == '0) ? PosW'(eff_len - 1'b1) : pos_q - 1'b1)
                              : ((pos_inc >= eff_len) ? '0 : pos_inc[PosW-1:0]);
  assign t_sum      = t_q + DivW'(inc_q);
  assign hit        = t_sum >= need_q;
  assign steps_inc  = steps_q + 1'b1;
  assign rate_cur   = (state_q == S_RWAIT) ? st_rsp.rate_rdata : fixed_rate_q;

  always_comb begin
    st_req.rate_we    = in_acc && (ttcw_pkg::mode_e'(mode_i) == ttcw_pkg::ModeLoad) &&
                        (position_i[PosW-1:GrpW] == '0);
    st_req.rate_waddr = position_i[GrpW-1:0];
    st_req.rate_wdata = rate_value_i;
    st_req.rate_raddr = pos_q[PosW-1:3];
    st_req.mark_we    = (state_q == S_STEP) && wfill_q;
    st_req.mark_waddr = pos_q[PosW-1:3];
    st_req.mark_raddr = position_i[GrpW-1:0];
  end

  always_comb begin
    state_d = state_q;  out_valid_d = out_valid_q;  phase_d = phase_q;
    rev_d = rev_q;  inc_ok_d = inc_ok_q;  stall_d = stall_q;
    mode_d = mode_q;  start_d = start_q;  pos_d = pos_q;  dur_d = dur_q;
    mag_d = mag_q;  neg_d = neg_q;  fill_d = fill_q;  back_d = back_q;
    wback_d = wback_q;  wfill_d = wfill_q;  grp_ok_d = grp_ok_q;
    need_d = need_q;  t_d = t_q;  steps_d = steps_q;  inc_d = inc_q;
    last_rate_d = last_rate_q;  res_pos_d = res_pos_q;  res_mark_d = res_mark_q;
    end_pos_d = end_pos_q;  mark_out_d = mark_out_q;  stall_out_d = stall_out_q;
    div_req.start = 1'b0;
    div_req.dividend = ttcw_pkg::RateDividend;
    div_req.divisor = DivW'(rate_cur);
    div_req.iters = ttcw_pkg::IterW'(ttcw_pkg::RateBits);

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_d     = ttcw_pkg::mode_e'(mode_i);
          start_d    = position_i;
          dur_d      = duration_us_i;
          neg_d      = off_raw[24];
          mag_d      = off_raw[24] ? (~off_raw + 1'b1) : off_raw;
          fill_d     = fill_i;
          back_d     = backward_i;
          grp_ok_d   = position_i[PosW-1:GrpW] == '0;
          phase_d    = 1'b0;
          stall_d    = 1'b0;
          res_pos_d  = '0;
          res_mark_d = 1'b0;
          unique case (ttcw_pkg::mode_e'(mode_i))
            ttcw_pkg::ModeLoad: state_d = S_OUT;
            ttcw_pkg::ModeMark: state_d = S_MARK;
            default:            state_d = S_INIT;
          endcase
        end
      end
      S_MARK: begin
        res_mark_d = st_rsp.mark_rdata && grp_ok_q;
        state_d    = S_OUT;
      end
      S_INIT: begin
        pos_d    = ({1'b0, start_sel} < eff_len) ? start_sel : '0;
        need_d   = (us_w << 10) - (us_w << 4) - (us_w << 3);
        wback_d  = first ? neg_q : back_q;
        wfill_d  = first ? 1'b0 : fill_q;
        t_d      = '0;
        steps_d  = '0;
        rev_d    = 1'b0;
        inc_ok_d = 1'b0;
        state_d  = S_RATE;
      end
      S_RATE, S_RWAIT: begin
        if ((state_q == S_RATE) && var_rate_q) begin
          state_d = S_RWAIT;
        end else if (rate_cur == '0 || (inc_ok_q && rate_cur == last_rate_q)) begin
          if (rate_cur == '0) begin
            inc_d = '0;
          end
          last_rate_d = rate_cur;
          inc_ok_d    = 1'b1;
          state_d     = S_STEP;
        end else begin
          div_req.start = 1'b1;
          last_rate_d   = rate_cur;
          state_d       = S_DIV;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          inc_d    = div_rsp.quot[ttcw_pkg::IncW-1:0];
          inc_ok_d = 1'b1;
          state_d  = S_STEP;
        end
      end
      S_STEP: begin
        pos_d = pos_next;
        t_d   = t_sum;
        if (hit || (!rev_q && steps_inc == eff_len && t_sum == '0)) begin
          if (!hit) begin
            stall_d = 1'b1;
          end
          if (first) begin
            start_d = pos_next;
            phase_d = 1'b1;
            state_d = S_INIT;
          end else begin
            res_pos_d = pos_next;
            state_d   = S_OUT;
          end
        end else if (!rev_q && steps_inc == eff_len) begin
          rev_d   = 1'b1;
          state_d = S_MODGO;
        end else begin
          steps_d = steps_inc;
          if (var_rate_q && (pos_next[PosW-1:3] != pos_q[PosW-1:3])) begin
            state_d = S_RATE;
          end
        end
      end
      S_MODGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = need_q - 1'b1 - t_q;
        div_req.divisor  = t_q;
        div_req.iters    = ttcw_pkg::IterW'(DivW);
        state_d          = S_MOD;
      end
      S_MOD: begin
        div_req.dividend = need_q - 1'b1 - t_q;
        div_req.divisor  = t_q;
        div_req.iters    = ttcw_pkg::IterW'(DivW);
        if (div_rsp.done) begin
          t_d     = need_q - 1'b1 - div_rsp.rem;
          state_d = S_RATE;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          end_pos_d   = res_pos_q;
          mark_out_d  = res_mark_q;
          stall_out_d = stall_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      rev_q       <= 1'b0;
      inc_ok_q    <= 1'b0;
      stall_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      rev_q       <= rev_d;
      inc_ok_q    <= inc_ok_d;
      stall_q     <= stall_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    start_q     <= start_d;
    pos_q       <= pos_d;
    dur_q       <= dur_d;
    mag_q       <= mag_d;
    neg_q       <= neg_d;
    fill_q      <= fill_d;
    back_q      <= back_d;
    wback_q     <= wback_d;
    wfill_q     <= wfill_d;
    grp_ok_q    <= grp_ok_d;
    need_q      <= need_d;
    t_q         <= t_d;
    steps_q     <= steps_d;
    inc_q       <= inc_d;
    last_rate_q <= last_rate_d;
    res_pos_q   <= res_pos_d;
    res_mark_q  <= res_mark_d;
    end_pos_q   <= end_pos_d;
    mark_out_q  <= mark_out_d;
    stall_out_q <= stall_out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign end_position_o = end_pos_q;
  assign mark_bit_o     = mark_out_q;
  assign stalled_o      = stall_out_q;

  `TTCW_ASSERT_IMP(a_div_start_idle, div_req.start, !div_rsp.busy)
  `TTCW_ASSERT_IMP(a_rev_time_below_need, state_q == S_STEP && rev_q, t_q < need_q)
  `TTCW_ASSERT_IMP(a_steps_below_len, state_q == S_STEP && !rev_q, steps_q < eff_len)

endmodule

// ===== test/testbench.sv =====
module testbench;

  localparam logic [1:0] CfgUnused = 2'd3;
  localparam logic [1:0] CfgTrack  = ttcw_pkg::CfgTrackCells;
  localparam logic [1:0] CfgVar    = ttcw_pkg::CfgVarRate;
  localparam logic [1:0] CfgFixed  = ttcw_pkg::CfgFixedRate;
  localparam ttcw_pkg::mode_e MdLoad = ttcw_pkg::ModeLoad;
  localparam ttcw_pkg::mode_e MdWalk = ttcw_pkg::ModeWalk;
  localparam ttcw_pkg::mode_e MdFill = ttcw_pkg::ModeFill;
  localparam ttcw_pkg::mode_e MdMark = ttcw_pkg::ModeMark;
  localparam int unsigned GroupCount = 32768;

  typedef struct {
    ttcw_pkg::mode_e mode;
    logic [17:0] position;
    logic [23:0] rate_value;
    logic [23:0] duration_us;
    logic signed [24:0] offset_us;
    logic        fill;
    logic        backward;
  } request_t;

  typedef struct {
    logic [17:0] end_position;
    logic        mark_bit;
    logic        stalled;
  } answer_t;

  typedef struct {
    request_t req;
    bit       typed;
    answer_t  ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = CfgTrack;
  logic [23:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = MdLoad;
  logic [17:0] position_i = '0;
  logic [23:0] rate_value_i = '0;
  logic [23:0] duration_us_i = '0;
  logic signed [24:0] offset_us_i = '0;
  logic fill_i = 1'b0;
  logic backward_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [17:0] end_position_o;
  logic mark_bit_o;
  logic stalled_o;

  track_time_to_cell_walker_core u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // track model
  logic [18:0] trk_cells = 19'd262144;
  logic        trk_var = 1'b0;
  logic [23:0] trk_fixed = 24'd250000;
  logic [23:0] rate_tab [GroupCount];
  bit          group_mark [GroupCount];

  answer_t pending_q[$];
  int errors = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  bit hold_go = 1'b0;
  bit hold_used = 1'b0;
  int n_walk = 0, n_fill = 0, n_load = 0, n_mark = 0, n_stall = 0, n_seen = 0;

  function automatic int unsigned track_len();
    if (trk_cells == 0) return 1;
    if (trk_cells > 19'd262144) return 262144;
    return trk_cells;
  endfunction

  function automatic int unsigned walk_track(int unsigned start, longint unsigned us,
                                             bit mark_on, bit back, inout bit stuck);
    int unsigned len, pos, g;
    longint unsigned need, t, steps, rate;
    len = track_len();
    pos = (start < len) ? start : 0;
    need = us * 1000;
    t = 0;
    steps = 0;
    while (1) begin
      g = pos >> 3;
      if (mark_on) group_mark[g] = 1'b1;
      rate = trk_var ? rate_tab[g] : trk_fixed;
      if (back) pos = (pos != 0) ? pos - 1 : len - 1;
      else begin
        pos++;
        if (pos >= len) pos = 0;
      end
      if (rate != 0) t += 64'd500000000 / rate;
      if (t >= need) break;
      steps++;
      if (steps == len) begin
        if (t == 0) begin
          stuck = 1'b1;
          break;
        end
        t += ((need - 1 - t) / t) * t;
      end
    end
    return pos;
  endfunction

  function automatic answer_t predict_walk(request_t r);
    answer_t a;
    bit stuck;
    bit neg;
    longint unsigned mag;
    int unsigned s;
    a = '{default: '0};
    stuck = 1'b0;
    case (r.mode)
      MdLoad: begin
        n_load++;
        if (r.position < GroupCount) rate_tab[r.position] = r.rate_value;
      end
      MdWalk: begin
        n_walk++;
        a.end_position = 18'(walk_track(r.position, r.duration_us, r.fill, r.backward,
                                        stuck));
      end
      MdFill: begin
        n_fill++;
        neg = r.offset_us[24];
        mag = neg ? (64'd33554432 - {39'd0, r.offset_us}) : {39'd0, r.offset_us};
        s = walk_track(0, mag, 1'b0, neg, stuck);
        a.end_position = 18'(walk_track(s, r.duration_us, r.fill, r.backward, stuck));
      end
      default: begin
        n_mark++;
        if (r.position < GroupCount) a.mark_bit = group_mark[r.position];
      end
    endcase
    a.stalled = stuck;
    if (stuck) n_stall++;
    return a;
  endfunction

  // long receiver hold, counted here
  always @(negedge clk_i) begin
    if (hold_go && !hold_used) begin
      hold_used   <= 1'b1;
      hold_cycles <= 400;
      out_stall_i <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk_i) begin
    answer_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_seen++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result end=%0d mark=%0b stalled=%0b", $time,
                 end_position_o, mark_bit_o, stalled_o);
      end else begin
        e = pending_q.pop_front();
        if (end_position_o !== e.end_position) begin
          errors++;
          $display("%0t: end_position expected %0d actual %0d", $time,
                   e.end_position, end_position_o);
        end
        if (mark_bit_o !== e.mark_bit) begin
          errors++;
          $display("%0t: mark_bit expected %0b actual %0b", $time, e.mark_bit, mark_bit_o);
        end
        if (stalled_o !== e.stalled) begin
          errors++;
          $display("%0t: stalled expected %0b actual %0b", $time, e.stalled, stalled_o);
        end
      end
    end
  end

  task automatic send_request(request_t r, bit typed, answer_t typed_ans);
    answer_t a;
    int gap;
    if ($urandom_range(99) < send_idle) begin
      gap = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= r.mode;
    position_i <= r.position;
    rate_value_i <= r.rate_value;
    duration_us_i <= r.duration_us;
    offset_us_i <= r.offset_us;
    fill_i <= r.fill;
    backward_i <= r.backward;
    do @(posedge clk_i); while (in_stall_o);
    a = predict_walk(r);
    pending_q.push_back(typed ? typed_ans : a);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgTrack: trk_cells = val[18:0];
      CfgVar:   trk_var = val[0];
      CfgFixed: trk_fixed = val;
      default: ;
    endcase
  endtask

  function automatic request_t random_request();
    request_t r;
    int unsigned len, pick;
    len = track_len();
    pick = $urandom_range(99);
    r.mode = (pick < 12) ? MdLoad : (pick < 55) ? MdWalk : (pick < 80) ? MdFill : MdMark;
    r.rate_value = ($urandom_range(3) == 0) ? 24'($urandom_range(0, 20)) : 24'($urandom);
    r.fill = 1'($urandom_range(1));
    r.backward = 1'($urandom_range(1));
    if ($urandom_range(9) < 7) begin
      if (r.mode == MdLoad || r.mode == MdMark)
        r.position = 18'($urandom_range(0, (len - 1) >> 3));
      else
        r.position = 18'($urandom_range(0, len - 1));
    end else begin
      r.position = 18'($urandom);
    end
    pick = $urandom_range(9);
    if (len > 4096) r.duration_us = 24'($urandom_range(0, 200));
    else if (pick < 5) r.duration_us = 24'($urandom_range(0, 300));
    else if (pick < 8) r.duration_us = 24'($urandom_range(0, 5000));
    else r.duration_us = 24'($urandom);
    if (len > 4096 || $urandom_range(1) == 0)
      r.offset_us = 25'(int'($urandom_range(0, 600)) - 300);
    else
      r.offset_us = 25'(longint'($urandom_range(0, 33554430)) - 16777215);
    return r;
  endfunction

  task automatic run_phase(logic [18:0] cells, bit var_mode, logic [23:0] fixed,
                           int count, bit zero_rates);
    request_t r;
    answer_t none;
    none = '{default: '0};
    write_reg(CfgTrack, {5'd0, cells});
    write_reg(CfgVar, {23'd0, var_mode});
    write_reg(CfgFixed, fixed);
    if (var_mode) begin
      for (int g = 0; g <= int'((track_len() - 1) >> 3); g++) begin
        r = '{MdLoad, 18'(g), zero_rates ? 24'd0 : 24'($urandom_range(1, 16777215)),
              '0, '0, 1'b0, 1'b0};
        send_request(r, 1'b0, none);
      end
    end
    for (int i = 0; i < count; i++) begin
      r = random_request();
      if (zero_rates && r.mode == MdLoad) r.rate_value = '0;
      send_request(r, 1'b0, none);
    end
    drain();
  endtask

  row_t rows [17];

  initial begin
    answer_t none;
    none = '{default: '0};
    rows = '{
      '{'{MdMark, 18'd0, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd0, 1'b0, 1'b0}},
      '{'{MdMark, 18'd262143, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd0, 1'b0, 1'b0}},
      '{'{MdLoad, 18'd32768, 24'hFFFFFF, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1,
        '{18'd0, 1'b0, 1'b0}},
      '{'{MdWalk, 18'd5, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd6, 1'b0, 1'b0}},
      '{'{MdWalk, 18'd0, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b1}, 1'b1,
        '{18'd262143, 1'b0, 1'b0}},
      '{'{MdWalk, 18'd262143, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd0, 1'b0, 1'b0}},
      '{'{MdWalk, 18'd10, 24'd0, 24'd1, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd11, 1'b0, 1'b0}},
      '{'{MdWalk, 18'd100, 24'd0, 24'hFFFFFF, 25'sd0, 1'b0, 1'b0}, 1'b0, none},
      '{'{MdWalk, 18'd7, 24'd0, 24'd40, 25'sd0, 1'b1, 1'b1}, 1'b0, none},
      '{'{MdMark, 18'd0, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b0, none},
      '{'{MdFill, 18'd0, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd2, 1'b0, 1'b0}},
      '{'{MdFill, 18'd0, 24'd0, 24'd100, -25'sd16777215, 1'b1, 1'b0}, 1'b0, none},
      '{'{MdFill, 18'h3FFFF, 24'd0, 24'd5, 25'sd16777215, 1'b1, 1'b1}, 1'b0, none},
      '{'{MdLoad, 18'd0, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd0, 1'b0, 1'b0}},
      '{'{MdLoad, 18'd32767, 24'd1, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1,
        '{18'd0, 1'b0, 1'b0}},
      '{'{MdMark, 18'd32767, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b0, none},
      '{'{MdMark, 18'd32768, 24'd0, 24'd0, 25'sd0, 1'b0, 1'b0}, 1'b1, '{18'd0, 1'b0, 1'b0}}
    };
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);

    send_idle = 18;
    recv_idle = 82;
    foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].ans);
    drain();
    write_reg(CfgUnused, 24'hFFFFFF);

    run_phase(19'd300, 1'b0, 24'd250000, 30, 1'b0);
    hold_go = 1'b1;
    run_phase(19'd1, 1'b0, 24'hFFFFFF, 40, 1'b0);
    run_phase(19'd0, 1'b1, 24'd250000, 30, 1'b1);
    run_phase(19'd512, 1'b1, 24'd0, 50, 1'b0);

    send_idle = 82;
    recv_idle = 18;
    run_phase(19'd64, 1'b0, 24'd0, 30, 1'b0);
    run_phase(19'd200, 1'b0, 24'd1, 30, 1'b0);
    run_phase(19'($urandom_range(64, 700)), 1'b1, 24'($urandom), 60, 1'b0);
    run_phase(19'h7FFFF, 1'b0, 24'hFFFFFF, 30, 1'b0);

    send_idle = 0;
    recv_idle = 0;
    run_phase(19'($urandom_range(64, 400)), 1'b1, 24'($urandom), 60, 1'b0);
    run_phase(19'($urandom_range(2, 600)), 1'b0, 24'($urandom_range(1, 16777215)), 50, 1'b0);
    run_phase(19'd262144, 1'b0, 24'd250000, 25, 1'b0);

    $display("covered %0d walks, %0d fill walks, %0d loads, %0d mark reads, %0d stalls",
             n_walk, n_fill, n_load, n_mark, n_stall);
    $display("%0d results checked across eleven track settings", n_seen);
    if (errors == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #800000000;
    $display("timeout");
    $display("testbench NOT OK");
    $finish;
  end

endmodule
